### hdl/mfrr_pkg.sv
package mfrr_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] ADDR_RESET    = 8'h02;
  localparam logic [7:0] LIMIT_RESET   = 8'd40;
  localparam logic [3:0] QTY_RESET     = 4'd0;

  // Input kind carried on tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_ADDR  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_QTY   = 2'd2;

  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_ADDR   = 4'd0,
    PH_FUNC   = 4'd1,
    PH_COUNT  = 4'd2,
    PH_DATA0  = 4'd3,
    PH_DATA1  = 4'd4,
    PH_DATA2  = 4'd5,
    PH_DATA3  = 4'd6,
    PH_CRC_LO = 4'd7,
    PH_CRC_HI = 4'd8
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value_bits;
    logic [7:0]  function_code;
    logic [7:0]  byte_count;
  } frame_res_t;

  // One byte of Modbus CRC-16, LSB first
  function automatic logic [15:0] mfrr_crc8(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/mfrr_frame.sv
module mfrr_frame import mfrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] byte_value,
  input  logic [7:0] expected_address,
  output logic       done,
  output frame_res_t res
);

  phase_t      phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  func, func_next;
  logic [7:0]  count, count_next;
  logic [31:0] data, data_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic [15:0] crc_step;

  assign crc_step = mfrr_crc8(crc, byte_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ADDR;
      crc   <= CRC_INIT;
    end else if (en) begin
      phase <= phase_next;
      crc   <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func   <= func_next;
      count  <= count_next;
      data   <= data_next;
      crc_lo <= crc_lo_next;
    end
  end

  always_comb begin
    phase_next   = phase;
    crc_next     = crc;
    func_next    = func;
    count_next   = count;
    data_next    = data;
    crc_lo_next  = crc_lo;
    done         = 1'b0;
    res.status        = ST_CRC_ERR;
    res.value_bits    = data;
    res.function_code = func;
    res.byte_count    = count;
    unique case (phase) inside
      PH_FUNC: begin
        func_next  = byte_value;
        crc_next   = crc_step;
        phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        count_next = byte_value;
        crc_next   = crc_step;
        phase_next = PH_DATA0;
      end
      PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3: begin
        data_next  = {data[23:0], byte_value};
        crc_next   = crc_step;
        phase_next = phase_t'(4'(phase + 4'd1));
      end
      PH_CRC_LO: begin
        crc_lo_next = byte_value;
        phase_next  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        done       = 1'b1;
        phase_next = PH_ADDR;
        if (crc_lo == crc[7:0] && byte_value == crc[15:8]) begin
          res.status = ST_OK;
        end
      end
      default: begin
        // hunt: drop anything but the station address
        phase_next = PH_ADDR;
        if (byte_value == expected_address) begin
          crc_next   = mfrr_crc8(CRC_INIT, byte_value);
          phase_next = PH_FUNC;
        end
      end
    endcase
  end

endmodule

### hdl/mfrr_timer.sv
module mfrr_timer import mfrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic [7:0] timeout_limit,
  output logic       fire
);

  logic [7:0] count;
  logic [7:0] count_inc;

  // wraps at 255 so a limit of 255 never fires
  assign count_inc = 8'(count + 8'd1);
  assign fire      = tick && (count_inc > timeout_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 8'd0;
    end else if (tick) begin
      count <= fire ? 8'd0 : count_inc;
    end
  end

endmodule

### hdl/modbus_float_reply_receiver.sv
// A result passes through the input register and then the output register on its way to the master side.
// Throughput: one input transaction per cycle while the master side takes results.
// The CRC is updated for a whole byte at a time; the tick counter sits beside the parser.
// Reset (rst, synchronous, active high): parser hunts for the address, CRC = 0xFFFF,
// tick count = 0, address = 0x02, timeout limit = 40, quantity index = 0, no result held.
module modbus_float_reply_receiver import mfrr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] byte_value
  input  logic                   s_axis_tuser,   // [0] operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [33:2] value_bits, [41:34] function_code, [49:42] byte_count,
  // [53:50] quantity_tag, [55:54] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data
);

  // Configuration registers
  logic [7:0] expected_address;
  logic [7:0] timeout_limit;
  logic [3:0] quantity_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= ADDR_RESET;
      timeout_limit    <= LIMIT_RESET;
      quantity_index   <= QTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADDR:  expected_address <= cfg_data;
        REG_LIMIT: timeout_limit    <= cfg_data;
        REG_QTY:   quantity_index   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register: hold one transaction until the result side can take it
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       proc;

  // advance when the output register is empty or being emptied this cycle
  assign proc          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  // Frame parser and tick counter see only their own kind of transaction
  logic       frame_done;
  frame_res_t frame_res;
  logic       timeout_fire;

  mfrr_frame u_frame (
    .clk              (clk),
    .rst              (rst),
    .en               (proc && in_op == OP_BYTE),
    .byte_value       (in_byte),
    .expected_address (expected_address),
    .done             (frame_done),
    .res              (frame_res)
  );

  mfrr_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .tick          (proc && in_op == OP_TICK),
    .timeout_limit (timeout_limit),
    .fire          (timeout_fire)
  );

  // Select the result for this transaction
  logic       res_valid;
  frame_res_t res;

  always_comb begin
    if (in_op == OP_TICK) begin
      res_valid         = timeout_fire;
      res.status        = ST_TIMEOUT;
      res.value_bits    = 32'd0;
      res.function_code = 8'd0;
      res.byte_count    = 8'd0;
    end else begin
      res_valid = frame_done;
      res       = frame_res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      m_axis_tdata <= {2'b00, quantity_index, res.byte_count, res.function_code,
                       res.value_bits, res.status};
    end
  end

endmodule

### hdl/mfrr_checker.sv
module mfrr_checker import mfrr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_CRC_ERR ||
                       m_axis_tdata[1:0] == ST_TIMEOUT))
    else $error("bad status code");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_TIMEOUT |-> m_axis_tdata[49:2] == 48'd0)
    else $error("timeout result carries frame data");

endmodule

bind modbus_float_reply_receiver mfrr_checker u_mfrr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
